>>> hdl/cuw_pkg.sv
// Shared types, constants and classification helpers for the card UID check block.
package cuw_pkg;

  // Table size default; the back end sizes its table and counter from this.
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Entries in the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes on the input.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Result event codes.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ACCEPT = 3'd1;
  localparam logic [2:0] EV_REJECT = 3'd2;
  localparam logic [2:0] EV_ADDED  = 3'd3;
  localparam logic [2:0] EV_FULL   = 3'd4;

  // Reader status constants.
  localparam logic [7:0] IRQ_DONE_MASK  = 8'h30;
  localparam logic [7:0] IRQ_TIMER_MASK = 8'h01;
  localparam logic [7:0] ERR_FAIL_MASK  = 8'h1B;
  localparam logic [6:0] REQ_MIN_LEVEL  = 7'd2;
  localparam logic [6:0] AC_MIN_LEVEL   = 7'd5;

  typedef struct packed {
    logic        command;
    logic [31:0] entry_uid;
    logic [7:0]  req_irq;
    logic [7:0]  req_error;
    logic [6:0]  req_level;
    logic [7:0]  ac_irq;
    logic [7:0]  ac_error;
    logic [6:0]  ac_level;
    logic [31:0] uid_bytes;
    logic [7:0]  check_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] card_uid;
    logic [31:0] last_uid;
    logic        last_valid;
  } result_t;

  // What the front end decided about a transaction.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_POLL_OK,
    OP_POLL_FAIL
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] uid;
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_PUT
  } back_state_t;

  // One reader exchange: a timer flag without done flags, an error bit of the fail mask,
  // or a short FIFO fails it.
  function automatic logic stage_ok(input logic [7:0] irq, input logic [7:0] err,
                                    input logic [6:0] level, input logic [6:0] need);
    logic timeout;
    timeout = ((irq & IRQ_DONE_MASK) == 8'h00) && ((irq & IRQ_TIMER_MASK) != 8'h00);
    return !timeout && ((err & ERR_FAIL_MASK) == 8'h00) && (level >= need);
  endfunction

  function automatic logic [7:0] uid_xor(input logic [31:0] uid);
    return uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24];
  endfunction

endpackage

>>> hdl/card_uid_check_and_whitelist_core.sv
// Top level of the card UID check and whitelist block.
// Card UID check and whitelist. Each transaction is either a whitelist add
// (command 0, entry_uid) or the outcome of one card poll (command 1) with the
// reader status after the request and anticollision exchanges. The front end
// classifies a poll on entry: it fails when an exchange timed out without a
// done flag, when an error bit of 0x1B is set, when the FIFO level is short
// (below 2 after request, below 5 after anticollision), or when the XOR of the
// four UID bytes differs from the check byte. Classified transactions wait in
// a two-entry queue, so push keeps being taken while the back end works, as
// long as the queue is not full. The back end handles one transaction at a
// time: an add writes the table when it is taken (event 3, or 4 when the
// table already holds TABLE_DEPTH entries); a good poll records the card as
// the last card and scans the table one entry a cycle through the table's
// registered read port. A result left unpopped holds the back end until it
// is taken. Each transaction gives exactly one result in arrival order; the
// result register holds it until popped. last_uid and last_valid show the
// state right after that transaction. Table entries are only read below the
// fill count, so the table needs no clearing after reset.
module card_uid_check_and_whitelist_core #(
  parameter int unsigned TABLE_DEPTH = cuw_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // input side
  input  logic             push,
  output logic             full,
  input  cuw_pkg::item_t   item,
  // result side
  output logic             empty,
  input  logic             pop,
  output cuw_pkg::result_t result
);

  logic         q_push;
  cuw_pkg::op_t q_wr_op;
  cuw_pkg::op_t q_rd_op;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  logic         res_valid;

  // classification on the way in
  cuw_front u_front (
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_wr_op)
  );

  // decouples acceptance from the table scan
  cuw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wr_op (q_wr_op),
    .rd    (q_pop),
    .rd_op (q_rd_op),
    .full  (q_full),
    .empty (q_empty)
  );

  // table, last card and the result register
  cuw_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_op      (q_rd_op),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (result)
  );

  assign full  = q_full;
  assign empty = !res_valid;

endmodule

>>> hdl/cuw_front.sv
// Front end: accepts transactions and classifies them into add, good poll or failed poll.
module cuw_front (
  input  logic           push,
  input  cuw_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output cuw_pkg::op_t   q_op
);

  logic poll_good;

  always_comb begin
    poll_good = cuw_pkg::stage_ok(item.req_irq, item.req_error, item.req_level,
                                  cuw_pkg::REQ_MIN_LEVEL) &&
                cuw_pkg::stage_ok(item.ac_irq, item.ac_error, item.ac_level,
                                  cuw_pkg::AC_MIN_LEVEL) &&
                (cuw_pkg::uid_xor(item.uid_bytes) == item.check_byte);
  end

  always_comb begin
    q_push = push && !q_full;
    if (item.command == cuw_pkg::CMD_ADD) begin
      q_op.kind = cuw_pkg::OP_ADD;
      q_op.uid  = item.entry_uid;
    end else if (poll_good) begin
      q_op.kind = cuw_pkg::OP_POLL_OK;
      q_op.uid  = item.uid_bytes;
    end else begin
      q_op.kind = cuw_pkg::OP_POLL_FAIL;
      q_op.uid  = item.uid_bytes;
    end
  end

endmodule

>>> hdl/cuw_queue.sv
// Short queue of classified operations between front and back end.
module cuw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  cuw_pkg::op_t wr_op,
  input  logic         rd,
  output cuw_pkg::op_t rd_op,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = (cuw_pkg::QUEUE_DEPTH > 1) ? $clog2(cuw_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(cuw_pkg::QUEUE_DEPTH + 1);

  cuw_pkg::op_t slot [cuw_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign full  = (fill == CW'(cuw_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_op = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(cuw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(cuw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hdl/cuw_back.sv
// Back end: whitelist table, last-card state, table scan and result register.
module cuw_back #(
  parameter int unsigned TABLE_DEPTH = cuw_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  cuw_pkg::op_t     q_op,
  output logic             q_pop,
  input  logic             res_pop,
  output logic             res_valid,
  output cuw_pkg::result_t res
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] allow_mem [TABLE_DEPTH];

  cuw_pkg::back_state_t state;
  cuw_pkg::back_state_t state_next;

  logic [CW-1:0]    allow_count;
  logic [31:0]      last_card;
  logic             last_seen;
  cuw_pkg::op_kind_t kind;
  logic [31:0]      uid;
  logic [2:0]       pend_ev;
  logic [CW-1:0]    scan_idx;
  logic [31:0]      rd_data;
  logic             rd_vld;
  logic             hit;

  logic take;
  logic issue;
  logic load;
  logic table_full;
  logic [2:0] ev_final;

  assign table_full = (allow_count == CW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cuw_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_op.kind == cuw_pkg::OP_POLL_OK && allow_count != '0) begin
            state_next = cuw_pkg::B_SCAN;
          end else begin
            state_next = cuw_pkg::B_PUT;
          end
        end
      end
      cuw_pkg::B_SCAN: begin
        if (scan_idx == allow_count && !rd_vld) begin
          state_next = cuw_pkg::B_PUT;
        end
      end
      cuw_pkg::B_PUT: begin
        if (!res_valid || res_pop) begin
          state_next = cuw_pkg::B_IDLE;
        end
      end
      default: state_next = cuw_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    take  = 1'b0;
    issue = 1'b0;
    load  = 1'b0;
    case (state)
      cuw_pkg::B_IDLE: take  = !q_empty;
      cuw_pkg::B_SCAN: issue = (scan_idx < allow_count);
      cuw_pkg::B_PUT:  load  = !res_valid || res_pop;
      default: begin
        take  = 1'b0;
        issue = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  assign q_pop = take;

  always_comb begin
    if (kind == cuw_pkg::OP_POLL_OK) begin
      ev_final = hit ? cuw_pkg::EV_ACCEPT : cuw_pkg::EV_REJECT;
    end else begin
      ev_final = pend_ev;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (take && q_op.kind == cuw_pkg::OP_ADD && !table_full) begin
      allow_mem[allow_count[AW-1:0]] <= q_op.uid;
    end
    if (issue) begin
      rd_data <= allow_mem[scan_idx[AW-1:0]];
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (take) begin
      kind     <= q_op.kind;
      uid      <= q_op.uid;
      scan_idx <= '0;
      hit      <= 1'b0;
      if (q_op.kind == cuw_pkg::OP_ADD) begin
        pend_ev <= table_full ? cuw_pkg::EV_FULL : cuw_pkg::EV_ADDED;
      end else begin
        pend_ev <= cuw_pkg::EV_NONE;
      end
    end else begin
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_vld && rd_data == uid) begin
        hit <= 1'b1;
      end
    end
    if (load) begin
      res.event_res <= ev_final;
      res.card_uid  <= (kind == cuw_pkg::OP_POLL_OK) ? uid : 32'h0;
      res.last_uid  <= last_card;
      res.last_valid <= last_seen;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cuw_pkg::B_IDLE;
      allow_count <= '0;
      last_card   <= 32'h0;
      last_seen   <= 1'b0;
      rd_vld      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (take && q_op.kind == cuw_pkg::OP_ADD && !table_full) begin
        allow_count <= allow_count + 1'b1;
      end
      if (take && q_op.kind == cuw_pkg::OP_POLL_OK) begin
        last_card <= q_op.uid;
        last_seen <= 1'b1;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the card UID check and whitelist core.
module tb;

  // Whitelist size of the instance; the predictor keeps a table of the same depth.
  localparam int unsigned WL_DEPTH = cuw_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned ITEM_W = $bits(cuw_pkg::item_t);
  localparam int unsigned RANDOM_TXNS = 930;
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Receiver blackout: starts once this many transactions went in, lasts this long.
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 80;
  // Window (in accepted transactions) with no idling on either side.
  localparam int unsigned QUIET_FROM = 650;
  localparam int unsigned QUIET_TO = 800;
  localparam int unsigned IDLE_PCT = 23;
  localparam int unsigned TAIL_CYCLES = 40;

  // Kinds of damage applied to an otherwise good poll.
  typedef enum int unsigned {
    BRK_REQ_TIMER,
    BRK_REQ_ERROR,
    BRK_REQ_SHORT,
    BRK_AC_TIMER,
    BRK_AC_ERROR,
    BRK_AC_SHORT,
    BRK_BAD_CHECK
  } defect_t;

  // A transaction waiting to be sent; drain asks the sender to wait until
  // every outstanding result has been popped before offering it.
  typedef struct {
    cuw_pkg::item_t it;
    bit             drain;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  cuw_pkg::item_t   item = '0;
  logic             full;
  logic             empty;
  cuw_pkg::result_t result;

  pending_t         reader_txns[$];   // stimulus not yet accepted
  cuw_pkg::result_t due_results[$];   // predicted results, oldest first

  // Predictor's own copy of the block state.
  logic [31:0] wl_entry[$];
  int unsigned wl_fill = 0;
  logic [31:0] recent_uid = '0;
  logic        recent_seen = 1'b0;

  // Generator bookkeeping: UIDs handed to add transactions so far.
  logic [31:0] offered_uids[$];

  int unsigned n_in = 0;
  int unsigned errs = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          item_taken = 1'b0;
  logic        quiet;

  assign quiet = (n_in >= QUIET_FROM) && (n_in < QUIET_TO);

  card_uid_check_and_whitelist_core #(
    .TABLE_DEPTH(WL_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One reader exchange. A timer flag only counts as a timeout when neither
  // done flag is up; then any error bit in the fail mask or a short FIFO fails.
  function automatic bit exchange_passes(input logic [7:0] irq, input logic [7:0] err,
                                         input logic [6:0] lvl, input logic [6:0] need);
    if (irq[5:4] == 2'b00 && irq[0])
      return 1'b0;
    if ((err & cuw_pkg::ERR_FAIL_MASK) != 8'h00)
      return 1'b0;
    return lvl >= need;
  endfunction

  // Block check byte: XOR of the four UID bytes.
  function automatic logic [7:0] bcc_of(input logic [31:0] uid);
    logic [7:0] acc;
    acc = 8'h00;
    for (int b = 0; b < 4; b++)
      acc ^= uid[8*b +: 8];
    return acc;
  endfunction

  // Applies one transaction to the predictor state and returns its result.
  function automatic cuw_pkg::result_t predict_outcome(input cuw_pkg::item_t t);
    cuw_pkg::result_t r;
    bit               hit;
    r = '0;
    r.event_res = cuw_pkg::EV_NONE;
    if (t.command == cuw_pkg::CMD_ADD) begin
      if (wl_fill >= WL_DEPTH) begin
        r.event_res = cuw_pkg::EV_FULL;
      end else begin
        wl_entry.push_back(t.entry_uid);
        wl_fill++;
        r.event_res = cuw_pkg::EV_ADDED;
      end
    end else if (exchange_passes(t.req_irq, t.req_error, t.req_level,
                                 cuw_pkg::REQ_MIN_LEVEL) &&
                 exchange_passes(t.ac_irq, t.ac_error, t.ac_level,
                                 cuw_pkg::AC_MIN_LEVEL) &&
                 bcc_of(t.uid_bytes) == t.check_byte) begin
      recent_uid = t.uid_bytes;
      recent_seen = 1'b1;
      r.card_uid = t.uid_bytes;
      hit = 1'b0;
      // only filled slots are looked at
      for (int i = 0; i < wl_fill; i++)
        if (wl_entry[i] == t.uid_bytes)
          hit = 1'b1;
      r.event_res = hit ? cuw_pkg::EV_ACCEPT : cuw_pkg::EV_REJECT;
    end
    r.last_uid = recent_uid;
    r.last_valid = recent_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Poll that passes every check, with random content in the don't-care bits.
  function automatic cuw_pkg::item_t good_poll(input logic [31:0] uid);
    cuw_pkg::item_t t;
    t = '0;
    t.command = cuw_pkg::CMD_POLL;
    t.entry_uid = $urandom;
    t.req_irq = 8'($urandom);
    t.ac_irq = 8'($urandom);
    // turn an accidental timeout into either a plain flag set or a done+timer
    if (t.req_irq[5:4] == 2'b00 && t.req_irq[0]) begin
      if ($urandom_range(0, 1)) t.req_irq[0] = 1'b0;
      else t.req_irq[4 + $urandom_range(0, 1)] = 1'b1;
    end
    if (t.ac_irq[5:4] == 2'b00 && t.ac_irq[0]) begin
      if ($urandom_range(0, 1)) t.ac_irq[0] = 1'b0;
      else t.ac_irq[4 + $urandom_range(0, 1)] = 1'b1;
    end
    t.req_error = 8'($urandom & ~cuw_pkg::ERR_FAIL_MASK);
    t.ac_error = 8'($urandom & ~cuw_pkg::ERR_FAIL_MASK);
    t.req_level = 7'($urandom_range(cuw_pkg::REQ_MIN_LEVEL, 64));
    t.ac_level = 7'($urandom_range(cuw_pkg::AC_MIN_LEVEL, 64));
    t.uid_bytes = uid;
    t.check_byte = bcc_of(uid);
    return t;
  endfunction

  function automatic cuw_pkg::item_t add_txn(input logic [31:0] uid);
    cuw_pkg::item_t t;
    t = cuw_pkg::item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
    t.command = cuw_pkg::CMD_ADD;
    t.entry_uid = uid;
    return t;
  endfunction

  // Picks one of the fail-mask bits of the error register.
  function automatic logic [7:0] fail_bit();
    logic [7:0] m;
    case ($urandom_range(0, 3))
      0: m = 8'h01;
      1: m = 8'h02;
      2: m = 8'h08;
      default: m = 8'h10;
    endcase
    return m;
  endfunction

  function automatic cuw_pkg::item_t broken_poll(input logic [31:0] uid);
    cuw_pkg::item_t t;
    defect_t        d;
    t = good_poll(uid);
    d = defect_t'($urandom_range(BRK_REQ_TIMER, BRK_BAD_CHECK));
    case (d)
      BRK_REQ_TIMER: t.req_irq = 8'(($urandom & ~cuw_pkg::IRQ_DONE_MASK) |
                                    cuw_pkg::IRQ_TIMER_MASK);
      BRK_REQ_ERROR: t.req_error = 8'($urandom | fail_bit());
      BRK_REQ_SHORT: t.req_level = 7'($urandom_range(0, cuw_pkg::REQ_MIN_LEVEL - 1));
      BRK_AC_TIMER:  t.ac_irq = 8'(($urandom & ~cuw_pkg::IRQ_DONE_MASK) |
                                   cuw_pkg::IRQ_TIMER_MASK);
      BRK_AC_ERROR:  t.ac_error = 8'($urandom | fail_bit());
      BRK_AC_SHORT:  t.ac_level = 7'($urandom_range(0, cuw_pkg::AC_MIN_LEVEL - 1));
      default:       t.check_byte = bcc_of(uid) ^ 8'($urandom_range(1, 255));
    endcase
    return t;
  endfunction

  // Half of the picks reuse a UID that was offered for the whitelist, once any was offered.
  function automatic logic [31:0] pick_uid();
    if (offered_uids.size() > 0 && $urandom_range(0, 1))
      return offered_uids[$urandom_range(0, offered_uids.size() - 1)];
    return $urandom;
  endfunction

  task automatic enqueue(input cuw_pkg::item_t t, input bit drain = 1'b0);
    pending_t p;
    p.it = t;
    p.drain = drain;
    reader_txns.push_back(p);
    if (t.command == cuw_pkg::CMD_ADD)
      offered_uids.push_back(t.entry_uid);
  endtask

  task automatic build_directed();
    cuw_pkg::item_t t;
    // all-zero poll: irq clear goes on to the error test, then FIFO level 0 fails
    t = '0;
    t.command = cuw_pkg::CMD_POLL;
    enqueue(t);
    // good card while the table is empty
    enqueue(good_poll(32'h1234_5678));
    // extreme UIDs and a duplicate entry
    enqueue(add_txn(32'h0000_0000));
    enqueue(add_txn(32'hFFFF_FFFF));
    enqueue(add_txn(32'hA5C3_0F96));
    enqueue(add_txn(32'hA5C3_0F96));
    enqueue(good_poll(32'h0000_0000));
    enqueue(good_poll(32'hFFFF_FFFF));
    enqueue(good_poll(32'hA5C3_0F96));
    // timer flag alone fails; timer together with done passes
    t = good_poll(32'h0102_0304); t.req_irq = cuw_pkg::IRQ_TIMER_MASK; enqueue(t);
    t = good_poll(32'h0102_0304); t.req_irq = 8'h31; enqueue(t);
    t = good_poll(32'h0102_0304); t.ac_irq = cuw_pkg::IRQ_TIMER_MASK; enqueue(t);
    t = good_poll(32'h8040_2010); t.req_irq = 8'hFF; t.ac_irq = 8'hFF; enqueue(t);
    // each error bit in the fail mask; bits outside the mask are harmless
    t = good_poll(32'h8040_2010); t.req_error = 8'h01; enqueue(t);
    t = good_poll(32'h8040_2010); t.req_error = 8'h02; enqueue(t);
    t = good_poll(32'h8040_2010); t.ac_error = 8'h08; enqueue(t);
    t = good_poll(32'h8040_2010); t.ac_error = 8'h10; enqueue(t);
    t = good_poll(32'hDEAD_BEEF); t.req_error = 8'hE4; t.ac_error = 8'hE4; enqueue(t);
    // FIFO level thresholds and the top of the range
    t = good_poll(32'hDEAD_BEEF); t.req_level = 7'(cuw_pkg::REQ_MIN_LEVEL - 1); enqueue(t);
    t = good_poll(32'hCAFE_F00D); t.req_level = cuw_pkg::REQ_MIN_LEVEL;
    t.ac_level = cuw_pkg::AC_MIN_LEVEL; enqueue(t);
    t = good_poll(32'hCAFE_F00D); t.ac_level = 7'(cuw_pkg::AC_MIN_LEVEL - 1); enqueue(t);
    t = good_poll(32'h7F7F_7F7F); t.req_level = 7'd64; t.ac_level = 7'd64; enqueue(t);
    // wrong check byte
    t = good_poll(32'h7F7F_7F7F); t.check_byte ^= 8'h80; enqueue(t);
  endtask

  task automatic build_random();
    cuw_pkg::item_t t;
    int unsigned    roll;
    for (int n = 0; n < RANDOM_TXNS; n++) begin
      roll = $urandom_range(0, 99);
      // adds are rare so the table fills gradually, then sit on table-full
      if (roll < 8)
        t = add_txn($urandom_range(0, 1) ? pick_uid() : $urandom);
      else if (roll < 68)
        t = good_poll(pick_uid());
      else if (roll < 90)
        t = broken_poll(pick_uid());
      else begin
        t = cuw_pkg::item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
        t.command = cuw_pkg::CMD_POLL;
        t.req_level = 7'($urandom_range(0, 64));
        t.ac_level = 7'($urandom_range(0, 64));
      end
      // sender waits for a full drain at the start of the random part and midway
      enqueue(t, n == 0 || n == 600);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the stimulus queue, holds it until accepted.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    bit offer;
    bit still_up;
    offer = 1'b0;
    if (!rst) begin
      if (item_taken) begin
        void'(reader_txns.pop_front());
        item_taken = 1'b0;
        still_up = 1'b0;
      end else begin
        still_up = push;
      end
      if (still_up) begin
        offer = 1'b1;
      end else if (reader_txns.size() > 0 &&
                   !(reader_txns[0].drain && due_results.size() > 0)) begin
        // no idling while the receiver is blacked out, so the block backs up
        offer = (hold_left > 0) || quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
    push <= offer;
    if (offer)
      item <= reader_txns[0].it;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop stalls plus one long blackout.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (!hold_done && n_in >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (quiet) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks popped results, then predicts for accepted transactions.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cuw_pkg::result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $error("result with no transaction outstanding: event_res %0d card_uid %h",
                 result.event_res, result.card_uid);
          errs++;
        end else begin
          want = due_results.pop_front();
          if (result.event_res !== want.event_res) begin
            $error("event_res expected %0d actual %0d", want.event_res, result.event_res);
            errs++;
          end
          if (result.card_uid !== want.card_uid) begin
            $error("card_uid expected %h actual %h", want.card_uid, result.card_uid);
            errs++;
          end
          if (result.last_uid !== want.last_uid) begin
            $error("last_uid expected %h actual %h", want.last_uid, result.last_uid);
            errs++;
          end
          if (result.last_valid !== want.last_valid) begin
            $error("last_valid expected %0d actual %0d", want.last_valid, result.last_valid);
            errs++;
          end
        end
      end
      if (push && !full) begin
        due_results.push_back(predict_outcome(item));
        item_taken = 1'b1;
        n_in++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the stimulus queue, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    do
      @(posedge clk);
    while (reader_txns.size() != 0 || push || due_results.size() != 0);
    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errs == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
